[sv/ipd_pkg.sv]
package ipd_pkg;

  // default sizes
  localparam int unsigned NUM_INTERRUPTS = 1024;
  localparam int unsigned NUM_THREADS    = 32;

  // fixed field and storage widths
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned INT_W       = 10;
  localparam int unsigned THR_W       = 5;
  localparam int unsigned OUTCOME_W   = 3;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BIT_W       = 5;
  localparam int unsigned PEND_ADDR_W = 5;
  localparam int unsigned FIFO_IDX_W  = 6;
  localparam int unsigned FIFO_CNT_W  = 7;
  localparam int unsigned THR_IDS     = 32;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_IRQ    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WAIT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

  // result outcomes
  localparam logic [OUTCOME_W-1:0] OC_DELIVERED = 3'd0;
  localparam logic [OUTCOME_W-1:0] OC_PENDED    = 3'd1;
  localparam logic [OUTCOME_W-1:0] OC_RETURNED  = 3'd2;
  localparam logic [OUTCOME_W-1:0] OC_QUEUED    = 3'd3;
  localparam logic [OUTCOME_W-1:0] OC_CANCELLED = 3'd4;
  localparam logic [OUTCOME_W-1:0] OC_NOTFOUND  = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [INT_W-1:0]  int_num;
    logic [THR_W-1:0]  thread_id;
  } in_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [THR_W-1:0]     thread_out;
    logic [INT_W-1:0]     int_out;
  } out_t;

  // pending bitmap port
  typedef struct packed {
    logic                   rd_en;
    logic [PEND_ADDR_W-1:0] rd_addr;
    logic                   wr_en;
    logic [PEND_ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0]      wr_data;
  } pend_ctl_t;

  typedef struct packed {
    logic [WORD_W-1:0]      rd_data;
    logic [BIT_W-1:0]       low_bit;
    logic                   any;
    logic [PEND_ADDR_W-1:0] first_word;
  } pend_sts_t;

  // waiter queue port, indexes are logical (0 is the oldest)
  typedef struct packed {
    logic                  rd_en;
    logic [FIFO_IDX_W-1:0] rd_idx;
    logic                  wr_en;
    logic [FIFO_IDX_W-1:0] wr_idx;
    logic [THR_W-1:0]      wr_data;
    logic                  cnt_inc;
    logic                  cnt_dec;
    logic                  head_inc;
    logic                  mem_set;
    logic                  mem_clr;
    logic [THR_W-1:0]      mem_thr;
  } fifo_ctl_t;

  typedef struct packed {
    logic [THR_W-1:0]      rd_data;
    logic [FIFO_CNT_W-1:0] count;
    logic [THR_IDS-1:0]    member;
  } fifo_sts_t;

endpackage

[sv/interrupt_pool_dispatcher.sv]
// channel | dir | handshake                 | payload
// in      | in  | in_valid_i / in_ready_o   | in_req_i  (kind, int_num, thread_id)
// out     | out | out_valid_o / out_ready_i | out_rsp_o (outcome, thread_out, int_out)
//
// one request at a time: in_ready_o is high only while the sequencer is idle
// pend, deliver and pending-return go through a registered read of the pending word or
// waiter ring, an update state (set, take or pop) and emit; a queued wait goes straight to emit
// a cancel that finds its thread scans every ring entry, a read then a compare, and closes
// the gap behind it; a cancel miss goes straight to emit; ignored requests stay in idle
// a stalled output holds the sequencer in emit
// reset clears the word flags, ring count and membership; no clearing pass
module interrupt_pool_dispatcher #(
  parameter int unsigned NumInterrupts = ipd_pkg::NUM_INTERRUPTS,
  parameter int unsigned NumThreads    = ipd_pkg::NUM_THREADS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ipd_pkg::in_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ipd_pkg::out_t out_rsp_o
);

  localparam int unsigned PendWords = (NumInterrupts + 31) / 32;
  localparam int unsigned WordAw    = (PendWords > 1) ? $clog2(PendWords) : 1;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SET      = 7'b0000010,
    S_TAKE     = 7'b0000100,
    S_POP      = 7'b0001000,
    S_SCAN_RD  = 7'b0010000,
    S_SCAN_CMP = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_e;

  state_e                           state_q, state_d;
  logic [ipd_pkg::INT_W-1:0]        irq_q, irq_d;
  logic [ipd_pkg::THR_W-1:0]        thr_q, thr_d;
  logic [ipd_pkg::PEND_ADDR_W-1:0]  word_q, word_d;
  logic [ipd_pkg::FIFO_CNT_W-1:0]   j_q, j_d;
  logic                             found_q, found_d;
  ipd_pkg::out_t                    res_q, res_d;
  ipd_pkg::out_t                    out_q, out_d;
  logic                             out_valid_q, out_valid_d;

  ipd_pkg::pend_ctl_t pctl;
  ipd_pkg::pend_sts_t psts;
  ipd_pkg::fifo_ctl_t fctl;
  ipd_pkg::fifo_sts_t fsts;

  logic                             irq_ok, thr_ok;
  logic [ipd_pkg::PEND_ADDR_W-1:0]  in_word;
  logic [ipd_pkg::FIFO_CNT_W-1:0]   j_next;

  ipd_pend #(
    .PendWords(PendWords)
  ) u_pend (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (pctl),
    .sts_o (psts)
  );

  ipd_fifo #(
    .Depth(NumThreads)
  ) u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (fctl),
    .sts_o (fsts)
  );

  // range checks on the incoming request
  assign irq_ok  = {1'b0, in_req_i.int_num} < (ipd_pkg::INT_W + 1)'(NumInterrupts);
  assign thr_ok  = {2'b0, in_req_i.thread_id} < (ipd_pkg::THR_W + 2)'(NumThreads);
  assign in_word = ipd_pkg::PEND_ADDR_W'(in_req_i.int_num[5 +: WordAw]);
  assign j_next  = ipd_pkg::FIFO_CNT_W'(j_q + ipd_pkg::FIFO_CNT_W'(1));

  // sequencer
  always_comb begin
    state_d     = state_q;
    irq_d       = irq_q;
    thr_d       = thr_q;
    word_d      = word_q;
    j_d         = j_q;
    found_d     = found_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    pctl        = '0;
    fctl        = '0;
    in_ready_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          irq_d = in_req_i.int_num;
          thr_d = in_req_i.thread_id;
          case (in_req_i.kind)
            ipd_pkg::KIND_IRQ: begin
              if (irq_ok) begin
                if (fsts.count != '0) begin
                  fctl.rd_en  = 1'b1;
                  fctl.rd_idx = '0;
                  state_d     = S_POP;
                end else begin
                  pctl.rd_en   = 1'b1;
                  pctl.rd_addr = in_word;
                  word_d       = in_word;
                  state_d      = S_SET;
                end
              end
            end
            ipd_pkg::KIND_WAIT: begin
              if (thr_ok) begin
                if (psts.any) begin
                  pctl.rd_en   = 1'b1;
                  pctl.rd_addr = psts.first_word;
                  word_d       = psts.first_word;
                  state_d      = S_TAKE;
                end else begin
                  // queue the thread unless it already waits
                  if (!fsts.member[in_req_i.thread_id]) begin
                    fctl.wr_en   = 1'b1;
                    fctl.wr_idx  = fsts.count[ipd_pkg::FIFO_IDX_W-1:0];
                    fctl.wr_data = in_req_i.thread_id;
                    fctl.cnt_inc = 1'b1;
                    fctl.mem_set = 1'b1;
                    fctl.mem_thr = in_req_i.thread_id;
                  end
                  res_d   = '{ipd_pkg::OC_QUEUED, in_req_i.thread_id, '0};
                  state_d = S_EMIT;
                end
              end
            end
            ipd_pkg::KIND_CANCEL: begin
              if (thr_ok) begin
                if (fsts.member[in_req_i.thread_id]) begin
                  j_d     = '0;
                  found_d = 1'b0;
                  state_d = S_SCAN_RD;
                end else begin
                  res_d   = '{ipd_pkg::OC_NOTFOUND, in_req_i.thread_id, '0};
                  state_d = S_EMIT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      // pend the interrupt
      S_SET: begin
        pctl.wr_en   = 1'b1;
        pctl.wr_addr = word_q;
        pctl.wr_data = psts.rd_data | (ipd_pkg::WORD_W'(1) << irq_q[4:0]);
        res_d        = '{ipd_pkg::OC_PENDED, '0, '0};
        state_d      = S_EMIT;
      end

      // hand out the lowest pending interrupt
      S_TAKE: begin
        pctl.wr_en   = 1'b1;
        pctl.wr_addr = word_q;
        pctl.wr_data = psts.rd_data & ~(ipd_pkg::WORD_W'(1) << psts.low_bit);
        res_d        = '{ipd_pkg::OC_RETURNED, thr_q, {word_q, psts.low_bit}};
        state_d      = S_EMIT;
      end

      // wake the oldest waiter
      S_POP: begin
        fctl.head_inc = 1'b1;
        fctl.cnt_dec  = 1'b1;
        fctl.mem_clr  = 1'b1;
        fctl.mem_thr  = fsts.rd_data;
        res_d         = '{ipd_pkg::OC_DELIVERED, fsts.rd_data, irq_q};
        state_d       = S_EMIT;
      end

      S_SCAN_RD: begin
        fctl.rd_en  = 1'b1;
        fctl.rd_idx = j_q[ipd_pkg::FIFO_IDX_W-1:0];
        state_d     = S_SCAN_CMP;
      end

      // find the thread, then close the gap one entry at a time
      S_SCAN_CMP: begin
        if (found_q) begin
          fctl.wr_en   = 1'b1;
          fctl.wr_idx  = ipd_pkg::FIFO_IDX_W'(j_q - ipd_pkg::FIFO_CNT_W'(1));
          fctl.wr_data = fsts.rd_data;
        end else if (fsts.rd_data == thr_q) begin
          found_d = 1'b1;
        end
        if (j_next == fsts.count) begin
          fctl.cnt_dec = 1'b1;
          fctl.mem_clr = 1'b1;
          fctl.mem_thr = thr_q;
          res_d        = '{ipd_pkg::OC_CANCELLED, thr_q, '0};
          state_d      = S_EMIT;
        end else begin
          j_d     = j_next;
          state_d = S_SCAN_RD;
        end
      end

      // move the result into the output register once it is free
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    irq_q   <= irq_d;
    thr_q   <= thr_d;
    word_q  <= word_d;
    j_q     <= j_d;
    found_q <= found_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

[sv/ipd_pend.sv]
module ipd_pend #(
  parameter int unsigned PendWords = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ipd_pkg::pend_ctl_t ctl_i,
  output ipd_pkg::pend_sts_t sts_o
);

  localparam int unsigned AW = (PendWords > 1) ? $clog2(PendWords) : 1;

  logic [ipd_pkg::WORD_W-1:0] mem_q [PendWords];
  logic [PendWords-1:0]       nz_q;
  logic [ipd_pkg::WORD_W-1:0] rd_q;
  logic                       rd_nz_q;
  logic [ipd_pkg::WORD_W-1:0] rd_word;

  // word storage, no reset: a word counts only while its flag is set
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[ctl_i.wr_addr[AW-1:0]] <= ctl_i.wr_data;
    end
    if (ctl_i.rd_en) begin
      rd_q    <= mem_q[ctl_i.rd_addr[AW-1:0]];
      rd_nz_q <= nz_q[ctl_i.rd_addr[AW-1:0]];
    end
  end

  // per-word nonzero flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q <= '0;
    end else if (ctl_i.wr_en) begin
      nz_q[ctl_i.wr_addr[AW-1:0]] <= |ctl_i.wr_data;
    end
  end

  assign rd_word = rd_q & {ipd_pkg::WORD_W{rd_nz_q}};

  // lowest nonzero word and lowest set bit of the read word
  always_comb begin
    sts_o.rd_data    = rd_word;
    sts_o.any        = |nz_q;
    sts_o.first_word = '0;
    sts_o.low_bit    = '0;
    for (int i = PendWords - 1; i >= 0; i--) begin
      if (nz_q[i]) begin
        sts_o.first_word = ipd_pkg::PEND_ADDR_W'(i);
      end
    end
    for (int b = ipd_pkg::WORD_W - 1; b >= 0; b--) begin
      if (rd_word[b]) begin
        sts_o.low_bit = ipd_pkg::BIT_W'(b);
      end
    end
  end

endmodule

[sv/ipd_fifo.sv]
module ipd_fifo #(
  parameter int unsigned Depth = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ipd_pkg::fifo_ctl_t ctl_i,
  output ipd_pkg::fifo_sts_t sts_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [ipd_pkg::THR_W-1:0]   mem_q [Depth];
  logic [ipd_pkg::THR_W-1:0]   rd_q;
  logic [AW-1:0]               head_q, head_d;
  logic [CW-1:0]               count_q, count_d;
  logic [ipd_pkg::THR_IDS-1:0] member_q, member_d;
  logic [AW-1:0]               rd_phys, wr_phys;

  // logical index to ring slot
  function automatic logic [AW-1:0] to_phys(logic [AW-1:0] head, logic [AW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= (AW + 1)'(Depth)) begin
      sum = sum - (AW + 1)'(Depth);
    end
    return sum[AW-1:0];
  endfunction

  assign rd_phys = to_phys(head_q, ctl_i.rd_idx[AW-1:0]);
  assign wr_phys = to_phys(head_q, ctl_i.wr_idx[AW-1:0]);

  // ring storage
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_phys] <= ctl_i.wr_data;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[rd_phys];
    end
  end

  // head, fill count and membership
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    member_d = member_q;
    if (ctl_i.head_inc) begin
      head_d = (head_q == AW'(Depth - 1)) ? '0 : AW'(head_q + AW'(1));
    end
    if (ctl_i.cnt_inc) begin
      count_d = CW'(count_q + CW'(1));
    end else if (ctl_i.cnt_dec) begin
      count_d = CW'(count_q - CW'(1));
    end
    if (ctl_i.mem_set) begin
      member_d[ctl_i.mem_thr] = 1'b1;
    end else if (ctl_i.mem_clr) begin
      member_d[ctl_i.mem_thr] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      member_q <= '0;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      member_q <= member_d;
    end
  end

  assign sts_o.rd_data = rd_q;
  assign sts_o.count   = ipd_pkg::FIFO_CNT_W'(count_q);
  assign sts_o.member  = member_q;

endmodule

[sv/ipd_chk.sv]
module ipd_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input ipd_pkg::in_t  in_req_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input ipd_pkg::out_t out_rsp_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // only defined outcomes leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.outcome <= ipd_pkg::OC_NOTFOUND))
    else $error("undefined outcome");

  // a pended interrupt names no thread and no interrupt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.outcome == ipd_pkg::OC_PENDED)
      |-> (out_rsp_o.thread_out == '0) && (out_rsp_o.int_out == '0))
    else $error("pended result carries data");

  // an unknown kind is dropped at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_req_i.kind == ipd_pkg::KIND_NONE) |=> in_ready_o)
    else $error("unknown kind held the sequencer");

endmodule

bind interrupt_pool_dispatcher ipd_chk u_ipd_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_req_i   (in_req_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_rsp_o  (out_rsp_o)
);
